>>> hdl/mpwm_pkg.sv
// Shared types, codes and constants of the multichannel PWM level controller.
// No dependencies; every module of the block imports this package.
`timescale 1ns / 1ps

package mpwm_pkg;

    localparam int NUM_CHANNELS   = 4;
    localparam int CH_W           = 2;
    localparam int LEVEL_W        = 16;
    localparam int LIMIT_W        = 14;
    localparam int CFG_W          = 28;
    localparam int CFG_ADDR_W     = 3;
    localparam int NUM_LIMIT_REGS = 4;

    localparam logic [LEVEL_W-1:0] LEVEL_CAP    = 16'd16383;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 16'hffff;
    localparam logic [CFG_W-1:0]   LIMITS_RESET = 28'd268419072;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CH0_LIMITS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CH1_LIMITS  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_CH2_LIMITS  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_CH3_LIMITS  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ON_OFF_MASK = 3'd4;

    typedef enum logic [2:0] {
        OP_SET_LEVEL  = 3'd0,
        OP_ADD_CLAMP  = 3'd1,
        OP_SAT_ADD    = 3'd2,
        OP_SET_OFF    = 3'd3,
        OP_TOGGLE_OFF = 3'd4,
        OP_TIMED      = 3'd5,
        OP_TICK       = 3'd6,
        OP_STATUS     = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        DRV_NONE = 2'd0,
        DRV_LOAD = 2'd1,
        DRV_STOP = 2'd2
    } t_drive;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_TICK,
        ST_DRIVE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic load;       // capture the request fields
        logic exec;       // run a channel command
        logic tick_init;  // snapshot expiring countdowns, start the scan
        logic tick_step;  // restore and count down the scanned channel
        logic advance;    // move the scan to the next channel
        logic drive;      // compute duty for the current channel
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic need_drive;
        logic tick_hit;
        logic scan_last;
    } t_dp_status;

endpackage

>>> hdl/multichannel_pwm_level_controller_unit.sv
// Four-channel PWM level controller. Each request (set level, add with clamp,
// saturating add, set or toggle off, timed pulse, tick, status) is taken one at
// a time: ready is high only while the unit is idle. A channel command goes
// through capture, execute and result, with a duty step between execute and
// result when it drives the output, that step using the shared duty multiplier
// that scales the level into the channel's min/max span. A tick scans the
// channels one per cycle while none expires, and each channel whose timed pulse
// expires passes through the duty step and the output register before the scan
// moves on, emitting one result per restored channel and none when nothing
// expires; its last result carries the last flag. Results wait in an output register until taken. Limit and mask
// registers are to be written through the plain write port only while the unit is idle; the unit does not enforce this.
`timescale 1ns / 1ps

module multichannel_pwm_level_controller_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mpwm_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [mpwm_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [2:0]                          i_op,
    input  logic [mpwm_pkg::CH_W-1:0]           i_channel,
    input  logic [mpwm_pkg::LEVEL_W-1:0]        i_level,
    input  logic signed [16:0]                  i_increment,
    input  logic                                i_off_value,
    input  logic [13:0]                         i_duration,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [mpwm_pkg::CH_W-1:0]           o_out_channel,
    output logic [1:0]                          o_drive,
    output logic [mpwm_pkg::LEVEL_W-1:0]        o_duty,
    output logic [mpwm_pkg::LEVEL_W-1:0]        o_cur_level,
    output logic                                o_is_off,
    output logic                                o_prior_updated,
    output logic                                o_last
);
    import mpwm_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    mpwm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    mpwm_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_level         (i_level),
        .i_increment     (i_increment),
        .i_off_value     (i_off_value),
        .i_duration      (i_duration),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_out_channel   (o_out_channel),
        .o_drive         (o_drive),
        .o_duty          (o_duty),
        .o_cur_level     (o_cur_level),
        .o_is_off        (o_is_off),
        .o_prior_updated (o_prior_updated),
        .o_last          (o_last)
    );

endmodule

>>> hdl/mpwm_ctrl.sv
// Sequencing state machine of the PWM level controller.
// Depends on mpwm_pkg; drives the datapath through t_dp_cmd and reads t_dp_status.
`timescale 1ns / 1ps

module mpwm_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_ready,
    input  mpwm_pkg::t_dp_status  i_status,
    output mpwm_pkg::t_dp_cmd     o_cmd
);
    import mpwm_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_status.is_tick) begin
                    o_cmd.tick_init = 1'b1;
                    n_state         = ST_TICK;
                end else begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_status.need_drive ? ST_DRIVE : ST_OUT;
                end
            end
            ST_TICK: begin
                o_cmd.tick_step = 1'b1;
                if (i_status.tick_hit) begin
                    n_state = ST_DRIVE;
                end else if (i_status.scan_last) begin
                    n_state = ST_IDLE;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            ST_DRIVE: begin
                o_cmd.drive = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    if (i_status.is_tick && !i_status.scan_last) begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_TICK;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == ST_EXEC))
        else $error("accepted request did not start execution");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("stalled result was dropped");

    a_drive_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.drive |=> (o_valid && !o_ready))
        else $error("duty computation not followed by a result");
`endif

endmodule

>>> hdl/mpwm_datapath.sv
// Channel state, configuration registers, level arithmetic and duty scaling.
// Depends on mpwm_pkg; controlled by mpwm_ctrl through t_dp_cmd.
`timescale 1ns / 1ps

module mpwm_datapath (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mpwm_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [mpwm_pkg::CFG_W-1:0]            i_cfg_wdata,
    input  logic [2:0]                            i_op,
    input  logic [mpwm_pkg::CH_W-1:0]             i_channel,
    input  logic [mpwm_pkg::LEVEL_W-1:0]          i_level,
    input  logic signed [16:0]                    i_increment,
    input  logic                                  i_off_value,
    input  logic [13:0]                           i_duration,
    input  mpwm_pkg::t_dp_cmd                     i_cmd,
    output mpwm_pkg::t_dp_status                  o_status,
    output logic [mpwm_pkg::CH_W-1:0]             o_out_channel,
    output logic [1:0]                            o_drive,
    output logic [mpwm_pkg::LEVEL_W-1:0]          o_duty,
    output logic [mpwm_pkg::LEVEL_W-1:0]          o_cur_level,
    output logic                                  o_is_off,
    output logic                                  o_prior_updated,
    output logic                                  o_last
);
    import mpwm_pkg::*;

    // captured request
    t_op                   r_op;
    logic [CH_W-1:0]       r_ch;
    logic [LEVEL_W-1:0]    r_lvl;
    logic signed [16:0]    r_inc;
    logic                  r_offv;
    logic [13:0]           r_dur;

    // channel state
    logic [LEVEL_W-1:0]    r_level [NUM_CHANNELS];
    logic [LEVEL_W-1:0]    r_saved [NUM_CHANNELS];
    logic [LEVEL_W-1:0]    r_ticks [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] r_off;
    logic [NUM_CHANNELS-1:0] r_upd;
    logic [NUM_CHANNELS-1:0] r_hit_mask;

    // configuration
    logic [CFG_W-1:0]          r_limits [NUM_LIMIT_REGS];
    logic [NUM_LIMIT_REGS-1:0] r_mask;

    // result register
    logic [CH_W-1:0]       r_o_ch;
    t_drive                r_o_drive;
    logic [LEVEL_W-1:0]    r_o_duty;
    logic [LEVEL_W-1:0]    r_o_level;
    logic                  r_o_off;
    logic                  r_o_upd;
    logic                  r_o_last;

    logic                  ch_ok;
    logic [LEVEL_W-1:0]    cur_lvl;
    logic signed [17:0]    add_sum;
    logic [LEVEL_W-1:0]    add_clamp_lvl;
    logic [LEVEL_W-1:0]    sat_lvl;
    logic [16:0]           dur5;
    logic [LEVEL_W-1:0]    pulse_ticks;
    logic [CFG_W-1:0]      lim;
    logic [LIMIT_W-1:0]    lim_lo;
    logic [LIMIT_W-1:0]    lim_hi;
    logic [LIMIT_W-1:0]    span;
    logic [LIMIT_W-1:0]    base;
    logic [LEVEL_W-1:0]    p_lvl;
    logic [29:0]           prod;
    logic [16:0]           duty_sum;
    logic [LEVEL_W-1:0]    duty;
    logic                  more_hits;

    assign ch_ok   = (32'(r_ch) < NUM_CHANNELS);
    assign cur_lvl = r_level[r_ch];

    // signed add used by both add commands
    assign add_sum = $signed({2'b00, cur_lvl}) + $signed({r_inc[16], r_inc});

    always_comb begin
        if (add_sum[17]) begin
            // would go below zero: keep level, still capped
            add_clamp_lvl = (cur_lvl > LEVEL_CAP) ? LEVEL_CAP : cur_lvl;
        end else if (add_sum > $signed({2'b00, LEVEL_CAP})) begin
            add_clamp_lvl = LEVEL_CAP;
        end else begin
            add_clamp_lvl = add_sum[LEVEL_W-1:0];
        end

        if (add_sum[17]) begin
            sat_lvl = '0;
        end else if (add_sum[16]) begin
            sat_lvl = LEVEL_MAX;
        end else begin
            sat_lvl = add_sum[LEVEL_W-1:0];
        end
    end

    // pulse length: five ticks per tenth, saturated to 16 bits
    assign dur5        = {1'b0, r_dur, 2'b00} + {3'b000, r_dur};
    assign pulse_ticks = dur5[16] ? LEVEL_MAX : dur5[LEVEL_W-1:0];

    // duty scaling into the limit span
    assign lim    = r_limits[r_ch];
    assign lim_lo = lim[LIMIT_W-1:0];
    assign lim_hi = lim[2*LIMIT_W-1:LIMIT_W];

    always_comb begin
        if (lim_hi >= lim_lo) begin
            span = lim_hi - lim_lo;
            base = lim_lo;
        end else begin
            span = lim_lo - lim_hi;
            base = lim_hi;
        end
        p_lvl    = r_mask[r_ch] ? LEVEL_CAP : cur_lvl;
        prod     = p_lvl * span;
        duty_sum = {1'b0, prod[29:LIMIT_W]} + {3'b000, base};
        duty     = (duty_sum > {1'b0, LEVEL_CAP}) ? LEVEL_CAP : duty_sum[LEVEL_W-1:0];
    end

    // another restore still pending later in the scan
    always_comb begin
        more_hits = 1'b0;
        for (int k = 0; k < NUM_CHANNELS; k++) begin
            if ((CH_W'(k) > r_ch) && r_hit_mask[k]) begin
                more_hits = 1'b1;
            end
        end
    end

    always_comb begin
        o_status.is_tick    = (r_op == OP_TICK);
        o_status.tick_hit   = (r_ticks[r_ch] == 16'd1);
        o_status.scan_last  = (r_ch == CH_W'(NUM_CHANNELS - 1));
        o_status.need_drive = 1'b0;
        if (ch_ok) begin
            case (r_op) inside
                OP_SET_LEVEL, OP_ADD_CLAMP, OP_SET_OFF, OP_TOGGLE_OFF: begin
                    o_status.need_drive = 1'b1;
                end
                default: begin
                    o_status.need_drive = 1'b0;
                end
            endcase
        end
    end

    // request capture and scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= t_op'(i_op);
            r_ch   <= i_channel;
            r_lvl  <= i_level;
            r_inc  <= i_increment;
            r_offv <= i_off_value;
            r_dur  <= i_duration;
        end else if (i_cmd.tick_init) begin
            r_ch <= '0;
        end else if (i_cmd.advance) begin
            r_ch <= r_ch + 1'b1;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LIMIT_REGS; k++) begin
                r_limits[k] <= LIMITS_RESET;
            end
            r_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CH0_LIMITS:  r_limits[0] <= i_cfg_wdata;
                CFG_CH1_LIMITS:  r_limits[1] <= i_cfg_wdata;
                CFG_CH2_LIMITS:  r_limits[2] <= i_cfg_wdata;
                CFG_CH3_LIMITS:  r_limits[3] <= i_cfg_wdata;
                CFG_ON_OFF_MASK: r_mask      <= i_cfg_wdata[NUM_LIMIT_REGS-1:0];
                default: begin
                end
            endcase
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_level[k] <= '0;
                r_saved[k] <= '0;
                r_ticks[k] <= '0;
            end
            r_off      <= '0;
            r_upd      <= '0;
            r_hit_mask <= '0;
        end else begin
            if (i_cmd.exec && ch_ok) begin
                case (r_op)
                    OP_SET_LEVEL: begin
                        r_level[r_ch] <= r_lvl;
                        r_ticks[r_ch] <= '0;
                    end
                    OP_ADD_CLAMP: begin
                        r_level[r_ch] <= add_clamp_lvl;
                        r_ticks[r_ch] <= '0;
                    end
                    OP_SAT_ADD: begin
                        r_level[r_ch] <= sat_lvl;
                    end
                    OP_SET_OFF: begin
                        r_off[r_ch] <= r_offv;
                    end
                    OP_TOGGLE_OFF: begin
                        r_off[r_ch] <= ~r_off[r_ch];
                    end
                    OP_TIMED: begin
                        if (!r_off[r_ch]) begin
                            r_saved[r_ch] <= cur_lvl;
                            r_level[r_ch] <= r_lvl;
                            r_ticks[r_ch] <= pulse_ticks;
                            r_upd[r_ch]   <= 1'b1;
                        end
                    end
                    OP_STATUS: begin
                        r_upd[r_ch] <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.tick_init) begin
                for (int k = 0; k < NUM_CHANNELS; k++) begin
                    r_hit_mask[k] <= (r_ticks[k] == 16'd1);
                end
            end
            if (i_cmd.tick_step) begin
                if (r_ticks[r_ch] == 16'd1) begin
                    r_level[r_ch] <= r_saved[r_ch];
                end
                if (r_ticks[r_ch] != '0) begin
                    r_ticks[r_ch] <= r_ticks[r_ch] - 1'b1;
                end
            end
            if (i_cmd.drive) begin
                r_upd[r_ch] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_o_ch    <= r_ch;
            r_o_drive <= DRV_NONE;
            r_o_duty  <= '0;
            r_o_level <= '0;
            r_o_off   <= 1'b0;
            r_o_upd   <= 1'b0;
            r_o_last  <= 1'b1;
            if (ch_ok) begin
                case (r_op)
                    OP_SAT_ADD: begin
                        r_o_level <= sat_lvl;
                        r_o_off   <= r_off[r_ch];
                    end
                    OP_TIMED: begin
                        if (r_off[r_ch]) begin
                            r_o_level <= cur_lvl;
                            r_o_off   <= 1'b1;
                        end else begin
                            r_o_drive <= DRV_LOAD;
                            r_o_duty  <= r_lvl;
                            r_o_level <= r_lvl;
                        end
                    end
                    OP_STATUS: begin
                        r_o_level <= cur_lvl;
                        r_o_off   <= r_off[r_ch];
                        r_o_upd   <= r_upd[r_ch];
                    end
                    default: begin
                    end
                endcase
            end
        end else if (i_cmd.drive) begin
            r_o_ch    <= r_ch;
            r_o_level <= cur_lvl;
            r_o_upd   <= 1'b0;
            r_o_last  <= (r_op == OP_TICK) ? !more_hits : 1'b1;
            if (r_off[r_ch]) begin
                r_o_drive <= DRV_STOP;
                r_o_duty  <= '0;
                r_o_off   <= 1'b1;
            end else begin
                r_o_drive <= DRV_LOAD;
                r_o_duty  <= duty;
                r_o_off   <= 1'b0;
            end
        end
    end

    assign o_out_channel   = r_o_ch;
    assign o_drive         = r_o_drive;
    assign o_duty          = r_o_duty;
    assign o_cur_level     = r_o_level;
    assign o_is_off        = r_o_off;
    assign o_prior_updated = r_o_upd;
    assign o_last          = r_o_last;

`ifndef NO_ASSERTIONS
    a_off_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.drive && r_off[r_ch]) |=> (r_o_drive == DRV_STOP && r_o_duty == '0))
        else $error("off channel was not stopped");

    a_drive_marks_updated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.drive |=> r_upd[$past(r_ch)])
        else $error("driven channel not marked updated");
`endif

endmodule

>>> test/multichannel_pwm_level_controller_unit_test.sv
// Self-checking bench for the four-channel PWM level controller: directed table, then random
// requests under several limit settings and idle patterns, checked against a local model.
// Depends on mpwm_pkg and multichannel_pwm_level_controller_unit.
`timescale 1ns / 1ps

module multichannel_pwm_level_controller_unit_test;

    import mpwm_pkg::*;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          TICK_SETTLE     = 24;
    localparam int          RX_HOLD_CYCLES  = 200;
    localparam int          RANDOM_PHASES   = 6;
    localparam int          ITEMS_PER_PHASE = 80;

    typedef struct packed {
        t_op                    op;
        logic [CH_W-1:0]        ch;
        logic [LEVEL_W-1:0]     level;
        logic signed [16:0]     inc;
        logic                   off_value;
        logic [13:0]            duration;
    } t_pwm_req;

    typedef struct packed {
        logic [CH_W-1:0]        ch;
        logic [1:0]             drive;
        logic [LEVEL_W-1:0]     duty;
        logic [LEVEL_W-1:0]     cur_level;
        logic                   is_off;
        logic                   prior_updated;
        logic                   last;
    } t_pwm_result;

    typedef struct packed {
        t_pwm_req               req;
        logic                   typed;
        t_pwm_result            res;
    } t_stim_row;

    localparam t_pwm_result NO_RESULT = '0;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_ADDR_W-1:0]      i_cfg_addr;
    logic [CFG_W-1:0]           i_cfg_wdata;
    logic                       i_valid;
    logic                       o_ready;
    logic [2:0]                 i_op;
    logic [CH_W-1:0]            i_channel;
    logic [LEVEL_W-1:0]         i_level;
    logic signed [16:0]         i_increment;
    logic                       i_off_value;
    logic [13:0]                i_duration;
    logic                       o_valid;
    logic                       i_ready = 1'b0;
    logic [CH_W-1:0]            o_out_channel;
    logic [1:0]                 o_drive;
    logic [LEVEL_W-1:0]         o_duty;
    logic [LEVEL_W-1:0]         o_cur_level;
    logic                       o_is_off;
    logic                       o_prior_updated;
    logic                       o_last;

    // model state of the channels and their settings
    logic [LEVEL_W-1:0]         pwm_level     [NUM_CHANNELS];
    logic [LEVEL_W-1:0]         pwm_saved     [NUM_CHANNELS];
    logic [LEVEL_W-1:0]         pwm_countdown [NUM_CHANNELS];
    logic                       pwm_off       [NUM_CHANNELS];
    logic                       pwm_updated   [NUM_CHANNELS];
    logic [CFG_W-1:0]           chan_limits   [NUM_LIMIT_REGS];
    logic [3:0]                 on_off_mask;

    t_pwm_result                expected_pwm_results [$];
    t_stim_row                  directed_rows [$];

    logic                       offered_typed = 1'b0;
    t_pwm_result                offered_expect = '0;
    int                         tx_idle_pct = 0;
    int                         rx_idle_pct = 0;
    bit                         rx_hold_req = 1'b0;
    int unsigned                cycle_count = 0;
    int unsigned                mismatch_count = 0;
    int unsigned                requests_accepted = 0;
    int unsigned                results_checked = 0;
    int unsigned                tick_restores = 0;

    multichannel_pwm_level_controller_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_channel       (i_channel),
        .i_level         (i_level),
        .i_increment     (i_increment),
        .i_off_value     (i_off_value),
        .i_duration      (i_duration),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_channel   (o_out_channel),
        .o_drive         (o_drive),
        .o_duty          (o_duty),
        .o_cur_level     (o_cur_level),
        .o_is_off        (o_is_off),
        .o_prior_updated (o_prior_updated),
        .o_last          (o_last)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_pwm_req make_req(input t_op op, input logic [CH_W-1:0] ch,
                                          input logic [LEVEL_W-1:0] lvl,
                                          input logic signed [16:0] inc,
                                          input logic offv, input logic [13:0] dur);
        t_pwm_req r;
        r.op        = op;
        r.ch        = ch;
        r.level     = lvl;
        r.inc       = inc;
        r.off_value = offv;
        r.duration  = dur;
        return r;
    endfunction

    function automatic t_pwm_result make_result(input logic [CH_W-1:0] ch, input t_drive drv,
                                                input logic [LEVEL_W-1:0] duty,
                                                input logic [LEVEL_W-1:0] cur,
                                                input logic off, input logic upd,
                                                input logic last);
        t_pwm_result r;
        r.ch            = ch;
        r.drive         = drv;
        r.duty          = duty;
        r.cur_level     = cur;
        r.is_off        = off;
        r.prior_updated = upd;
        r.last          = last;
        return r;
    endfunction

    // level scaled into the channel's min/max span, or a stop when the channel is off
    function automatic t_pwm_result scaled_drive(input int ch);
        logic [LIMIT_W-1:0] lo;
        logic [LIMIT_W-1:0] hi;
        int unsigned        span;
        int unsigned        base;
        int unsigned        p;
        int unsigned        d;
        lo = chan_limits[ch][LIMIT_W-1:0];
        hi = chan_limits[ch][2*LIMIT_W-1:LIMIT_W];
        pwm_updated[ch] = 1'b1;
        if (pwm_off[ch]) begin
            return make_result(CH_W'(ch), DRV_STOP, '0, pwm_level[ch], 1'b1, 1'b0, 1'b0);
        end
        if (hi >= lo) begin
            span = 32'(hi) - 32'(lo);
            base = 32'(lo);
        end else begin
            span = 32'(lo) - 32'(hi);
            base = 32'(hi);
        end
        p = on_off_mask[ch] ? 32'(LEVEL_CAP) : 32'(pwm_level[ch]);
        d = ((p * span) >> LIMIT_W) + base;
        if (d > 32'(LEVEL_CAP)) d = 32'(LEVEL_CAP);
        return make_result(CH_W'(ch), DRV_LOAD, d[LEVEL_W-1:0], pwm_level[ch], 1'b0, 1'b0, 1'b0);
    endfunction

    function automatic void predict_pwm_request(input t_pwm_req r);
        int           ch;
        int           sum;
        int           incv;
        int           pushed_before;
        int unsigned  t;
        logic [15:0]  k;
        ch = int'(r.ch);
        incv = int'(r.inc);
        pushed_before = expected_pwm_results.size();
        case (r.op)
            OP_TICK: begin
                for (int i = 0; i < NUM_CHANNELS; i++) begin
                    k = pwm_countdown[i];
                    if (k == 16'd1) begin
                        pwm_level[i] = pwm_saved[i];
                        expected_pwm_results.push_back(scaled_drive(i));
                        tick_restores++;
                    end
                    if (k != 16'd0) pwm_countdown[i] = k - 16'd1;
                end
            end
            OP_SET_LEVEL: begin
                pwm_level[ch] = r.level;
                pwm_countdown[ch] = '0;
                expected_pwm_results.push_back(scaled_drive(ch));
            end
            OP_ADD_CLAMP: begin
                sum = int'(pwm_level[ch]);
                // a decrement that would go below zero leaves the level alone
                if (incv > 0) sum += incv;
                else if (sum >= -incv) sum += incv;
                if (sum > int'(LEVEL_CAP)) sum = int'(LEVEL_CAP);
                pwm_level[ch] = LEVEL_W'(sum);
                pwm_countdown[ch] = '0;
                expected_pwm_results.push_back(scaled_drive(ch));
            end
            OP_SAT_ADD: begin
                sum = int'(pwm_level[ch]) + incv;
                if (sum > int'(LEVEL_MAX)) sum = int'(LEVEL_MAX);
                if (sum < 0) sum = 0;
                pwm_level[ch] = LEVEL_W'(sum);
                expected_pwm_results.push_back(make_result(r.ch, DRV_NONE, '0, pwm_level[ch],
                                                           pwm_off[ch], 1'b0, 1'b0));
            end
            OP_SET_OFF: begin
                pwm_off[ch] = r.off_value;
                expected_pwm_results.push_back(scaled_drive(ch));
            end
            OP_TOGGLE_OFF: begin
                pwm_off[ch] = ~pwm_off[ch];
                expected_pwm_results.push_back(scaled_drive(ch));
            end
            OP_TIMED: begin
                if (pwm_off[ch]) begin
                    expected_pwm_results.push_back(make_result(r.ch, DRV_NONE, '0, pwm_level[ch],
                                                               1'b1, 1'b0, 1'b0));
                end else begin
                    pwm_saved[ch] = pwm_level[ch];
                    pwm_level[ch] = r.level;
                    t = 32'(r.duration) * 32'd5;
                    pwm_countdown[ch] = (t > 32'(LEVEL_MAX)) ? LEVEL_MAX : t[LEVEL_W-1:0];
                    pwm_updated[ch] = 1'b1;
                    expected_pwm_results.push_back(make_result(r.ch, DRV_LOAD, r.level, r.level,
                                                               1'b0, 1'b0, 1'b0));
                end
            end
            default: begin
                expected_pwm_results.push_back(make_result(r.ch, DRV_NONE, '0, pwm_level[ch],
                                                           pwm_off[ch], pwm_updated[ch], 1'b0));
                pwm_updated[ch] = 1'b0;
            end
        endcase
        if (expected_pwm_results.size() > pushed_before)
            expected_pwm_results[expected_pwm_results.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                   input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                     $time, what, want_v, got_v);
    endtask

    task automatic check_pwm_result();
        t_pwm_result want;
        if (expected_pwm_results.size() == 0) begin
            report_mismatch("result with no request pending", 0, 32'(o_out_channel));
            return;
        end
        want = expected_pwm_results.pop_front();
        results_checked++;
        if (o_out_channel !== want.ch)
            report_mismatch("out_channel", 32'(want.ch), 32'(o_out_channel));
        if (o_drive !== want.drive)
            report_mismatch("drive", 32'(want.drive), 32'(o_drive));
        if (o_duty !== want.duty)
            report_mismatch("duty", 32'(want.duty), 32'(o_duty));
        if (o_cur_level !== want.cur_level)
            report_mismatch("cur_level", 32'(want.cur_level), 32'(o_cur_level));
        if (o_is_off !== want.is_off)
            report_mismatch("is_off", 32'(want.is_off), 32'(o_is_off));
        if (o_prior_updated !== want.prior_updated)
            report_mismatch("prior_updated", 32'(want.prior_updated), 32'(o_prior_updated));
        if (o_last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(o_last));
    endtask

    // everything is sampled here at the rising edge, inputs having settled at the falling one
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_addr <= CFG_CH3_LIMITS) chan_limits[i_cfg_addr[1:0]] = i_cfg_wdata;
                else if (i_cfg_addr == CFG_ON_OFF_MASK) on_off_mask = i_cfg_wdata[3:0];
            end
            if (i_valid && o_ready) begin
                requests_accepted++;
                predict_pwm_request(make_req(t_op'(i_op), i_channel, i_level, i_increment,
                                             i_off_value, i_duration));
                if (offered_typed && expected_pwm_results.size() != 0)
                    expected_pwm_results[expected_pwm_results.size() - 1] = offered_expect;
            end
            if (o_valid && i_ready) check_pwm_result();
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_pwm_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // result side: random stalls, or one long hold-off on request
    always begin
        @(negedge i_clk);
        if (rx_hold_req) begin
            i_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge i_clk);
            rx_hold_req = 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic offer(input t_pwm_req r, input logic typed, input t_pwm_result typed_res);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid        <= 1'b1;
        i_op           <= r.op;
        i_channel      <= r.ch;
        i_level        <= r.level;
        i_increment    <= r.inc;
        i_off_value    <= r.off_value;
        i_duration     <= r.duration;
        offered_typed  = typed;
        offered_expect = typed_res;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_pwm_results.size() != 0) @(posedge i_clk);
    endtask

    // 0: all-zero limits, full mask; 1: all-one limits; 2: min above max; else random
    task automatic program_limits(input int setting);
        logic [CFG_W-1:0] lim;
        logic [3:0]       mask;
        for (int i = 0; i < NUM_LIMIT_REGS; i++) begin
            case (setting)
                0:       lim = '0;
                1:       lim = '1;
                2:       lim = CFG_W'(LEVEL_CAP);
                default: lim = CFG_W'($urandom);
            endcase
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_addr  <= CFG_CH0_LIMITS + CFG_ADDR_W'(i);
            i_cfg_wdata <= lim;
        end
        case (setting)
            0:       mask = 4'hf;
            1:       mask = 4'h0;
            default: mask = 4'($urandom_range(15));
        endcase
        @(negedge i_clk);
        i_cfg_addr  <= CFG_ON_OFF_MASK;
        i_cfg_wdata <= CFG_W'(mask);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_pwm_req random_request();
        t_pwm_req    r;
        int unsigned pick;
        pick = $urandom_range(99);
        // ticks and timed pulses weighted up so countdowns actually expire
        if (pick < 16)      r.op = OP_TICK;
        else if (pick < 30) r.op = OP_TIMED;
        else                r.op = t_op'($urandom_range(7));
        r.ch = CH_W'($urandom_range(3));
        case ($urandom_range(4))
            0:       r.level = '0;
            1:       r.level = LEVEL_MAX;
            2:       r.level = LEVEL_CAP;
            3:       r.level = LEVEL_W'($urandom_range(20000));
            default: r.level = LEVEL_W'($urandom);
        endcase
        case ($urandom_range(5))
            0:       r.inc = 17'h10000;
            1:       r.inc = -17'sd65535;
            2:       r.inc = 17'sd65535;
            3:       r.inc = 17'(int'($urandom_range(200)) - 100);
            default: r.inc = 17'($urandom);
        endcase
        r.off_value = 1'($urandom_range(1));
        r.duration  = ($urandom_range(3) != 0) ? 14'($urandom_range(3)) : 14'($urandom);
        return r;
    endfunction

    initial begin
        t_stim_row row;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_addr  = '0;
        i_cfg_wdata = '0;
        i_valid     = 1'b0;
        i_op        = '0;
        i_channel   = '0;
        i_level     = '0;
        i_increment = '0;
        i_off_value = 1'b0;
        i_duration  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            pwm_level[i]     = '0;
            pwm_saved[i]     = '0;
            pwm_countdown[i] = '0;
            pwm_off[i]       = 1'b0;
            pwm_updated[i]   = 1'b0;
        end
        for (int i = 0; i < NUM_LIMIT_REGS; i++) chan_limits[i] = LIMITS_RESET;
        on_off_mask = '0;

        // reset limits: min 0, max 16383, no on-off-only channel
        directed_rows = '{
            {make_req(OP_STATUS,     2'd0, 16'd0,     17'sd0,      1'b0, 14'd0),
             1'b1, make_result(2'd0, DRV_NONE, 16'd0,     16'd0,     1'b0, 1'b0, 1'b1)},
            {make_req(OP_SET_LEVEL,  2'd0, 16'hffff,  17'sd0,      1'b0, 14'd0),
             1'b1, make_result(2'd0, DRV_LOAD, 16'd16383, 16'hffff,  1'b0, 1'b0, 1'b1)},
            {make_req(OP_SET_LEVEL,  2'd1, 16'd0,     17'sd0,      1'b0, 14'd0),
             1'b1, make_result(2'd1, DRV_LOAD, 16'd0,     16'd0,     1'b0, 1'b0, 1'b1)},
            {make_req(OP_ADD_CLAMP,  2'd0, 16'd0,     17'sd65535,  1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_ADD_CLAMP,  2'd1, 16'd0,     -17'sd65535, 1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_ADD_CLAMP,  2'd1, 16'd0,     17'h10000,   1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_SAT_ADD,    2'd2, 16'd0,     17'sd65535,  1'b0, 14'd0),
             1'b1, make_result(2'd2, DRV_NONE, 16'd0,     16'hffff,  1'b0, 1'b0, 1'b1)},
            {make_req(OP_SAT_ADD,    2'd2, 16'd0,     17'sd65535,  1'b0, 14'd0),
             1'b1, make_result(2'd2, DRV_NONE, 16'd0,     16'hffff,  1'b0, 1'b0, 1'b1)},
            {make_req(OP_SAT_ADD,    2'd2, 16'd0,     17'h10000,   1'b0, 14'd0),
             1'b1, make_result(2'd2, DRV_NONE, 16'd0,     16'd0,     1'b0, 1'b0, 1'b1)},
            {make_req(OP_SAT_ADD,    2'd3, 16'd0,     -17'sd1,     1'b0, 14'd0),
             1'b1, make_result(2'd3, DRV_NONE, 16'd0,     16'd0,     1'b0, 1'b0, 1'b1)},
            {make_req(OP_SET_OFF,    2'd1, 16'd0,     17'sd0,      1'b1, 14'd0),
             1'b1, make_result(2'd1, DRV_STOP, 16'd0,     16'd0,     1'b1, 1'b0, 1'b1)},
            {make_req(OP_TIMED,      2'd1, 16'd999,   17'sd0,      1'b0, 14'd7),
             1'b1, make_result(2'd1, DRV_NONE, 16'd0,     16'd0,     1'b1, 1'b0, 1'b1)},
            {make_req(OP_TOGGLE_OFF, 2'd1, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_TOGGLE_OFF, 2'd1, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_SET_OFF,    2'd1, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_STATUS,     2'd1, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_STATUS,     2'd1, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_TIMED,      2'd2, 16'hffff,  17'sd0,      1'b0, 14'h3fff),
             1'b1, make_result(2'd2, DRV_LOAD, 16'hffff,  16'hffff,  1'b0, 1'b0, 1'b1)},
            {make_req(OP_TIMED,      2'd3, 16'd1234,  17'sd0,      1'b0, 14'd1), 1'b0, NO_RESULT},
            {make_req(OP_TIMED,      2'd0, 16'd77,    17'sd0,      1'b0, 14'd1), 1'b0, NO_RESULT},
            {make_req(OP_TIMED,      2'd2, 16'd500,   17'sd0,      1'b0, 14'd1), 1'b0, NO_RESULT},
            {make_req(OP_TICK,       2'd0, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_TICK,       2'd3, 16'hffff,  17'sd0,      1'b1, 14'h3fff), 1'b0, NO_RESULT},
            {make_req(OP_TICK,       2'd1, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_TICK,       2'd2, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            // three timed pulses expire on this tick
            {make_req(OP_TICK,       2'd0, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT},
            {make_req(OP_STATUS,     2'd3, 16'd0,     17'sd0,      1'b0, 14'd0), 1'b0, NO_RESULT}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct = 33;
        rx_idle_pct = 48;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            offer(row.req, row.typed, row.res);
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            // a tick with nothing expiring gives no result, so let it finish before writing
            drain_results();
            repeat (TICK_SETTLE) @(posedge i_clk);
            program_limits(phase);
            case (phase / 2)
                0:       begin tx_idle_pct = 33; rx_idle_pct = 48; end
                1:       begin tx_idle_pct = 48; rx_idle_pct = 33; end
                default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
            endcase
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (phase == 2 && k == 10) rx_hold_req = 1'b1;
                if (phase == 3 && k == 40) drain_results();
                offer(random_request(), 1'b0, NO_RESULT);
            end
        end

        drain_results();
        repeat (TICK_SETTLE) @(posedge i_clk);
        if (expected_pwm_results.size() != 0)
            report_mismatch("results never produced", 0, expected_pwm_results.size());

        $display("%0d requests (%0d from the directed table), %0d results checked",
                 requests_accepted, directed_rows.size(), results_checked);
        $display("%0d tick restores; limits: reset, all zero, all one, min above max, random",
                 tick_restores);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
